### sv/lkvc_pkg.sv
// Shared constants, codes and types of the LRU key-value cache.
package lkvc_pkg;

   // Store geometry.
   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int RANK_BITS  = $clog2(ENTRIES);
   localparam int OCC_BITS   = $clog2(ENTRIES + 1);

   // Field widths fixed by the interface.
   localparam int ACTION_BITS   = 2;
   localparam int CAP_BITS      = 5;
   localparam int OCC_OUT_BITS  = 5;
   localparam int REQ_DATA_BITS = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((1 + VALUE_BITS + OCC_OUT_BITS + 7) / 8) * 8;

   // Action codes.
   localparam logic [ACTION_BITS-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd2;

   // Register file.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] CAP_WORD  = '0;
   localparam logic [CAP_BITS-1:0]      CAP_RESET = 5'd16;

   // One command word as held in the input register.
   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [KEY_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]  value;
   } cmd_type;

   // One result word as produced by the store.
   typedef struct packed {
      logic                    hit;
      logic [VALUE_BITS-1:0]   read_value;
      logic [OCC_OUT_BITS-1:0] occupancy;
   } rsp_type;

endpackage

### sv/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
//
// Each request word is a lookup, an insert or update, or a clear, and yields
// exactly one response word. A request is captured in the input register;
// once the response register is free or drains, the store matches its key
// against all entries in parallel, updates the recency ranks and loads the
// response register. The cache takes one request per cycle while responses
// are not stalled; each response word passes the input register and then
// the response register. Only a stalled response register holds up new
// requests. The capacity register (address 0) limits how many entries are
// used before the least recently used one is evicted; 0 acts as 1, values
// above 16 as 16. Reset empties the cache and sets the capacity to 16.
module lru_key_value_cache (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lkvc_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // key, value
   input  logic [lkvc_pkg::ACTION_BITS-1:0]      req_tuser,  // action
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lkvc_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // hit, read_value, occupancy, pad
   // Configuration port.
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [lkvc_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [lkvc_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import lkvc_pkg::*;

   logic                cmd_valid_ff;
   cmd_type             cmd_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                advance;
   logic [CAP_BITS-1:0] capacity;

   // A captured word moves on when the response register is free or drains.
   assign advance    = cmd_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !cmd_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_tready) begin
         cmd_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff.action <= req_tuser;
         cmd_ff.key    <= req_tdata[KEY_BITS-1:0];
         cmd_ff.value  <= req_tdata[KEY_BITS +: VALUE_BITS];
      end
   end

   lkvc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   lkvc_store u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (advance),
      .cmd       (cmd_ff),
      .capacity  (capacity),
      .rsp       (rsp_in)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_ff.occupancy, rsp_ff.read_value, rsp_ff.hit});

endmodule

### sv/lkvc_csr.sv
// APB-style register file holding the capacity register.
module lkvc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lkvc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [lkvc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output logic [lkvc_pkg::CAP_BITS-1:0]      capacity
);
   import lkvc_pkg::*;

   logic [CAP_BITS-1:0] capacity_ff;
   logic                cap_sel;
   logic                cap_write;

   // Decode the word address; the low two bits are the byte offset.
   assign cap_sel   = (csr_paddr[CSR_ADDR_BITS-1:2] == CAP_WORD);
   assign cap_write = csr_psel && csr_penable && csr_pwrite && cap_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (cap_write) begin
         capacity_ff <= csr_pwdata[CAP_BITS-1:0];
      end
   end

   // Reads return the register zero-extended; other words read as zero.
   assign csr_prdata = cap_sel ? CSR_DATA_BITS'(capacity_ff) : '0;
   assign csr_pready = 1'b1;
   assign capacity   = capacity_ff;

endmodule

### sv/lkvc_store.sv
// Entry store: parallel key match, recency ranks, eviction and fill in one pass.
module lkvc_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  lkvc_pkg::cmd_type             cmd,
   input  logic [lkvc_pkg::CAP_BITS-1:0] capacity,
   output lkvc_pkg::rsp_type             rsp
);
   import lkvc_pkg::*;

   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [KEY_BITS-1:0]   key_in   [ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic [VALUE_BITS-1:0] value_in [ENTRIES];
   logic [RANK_BITS-1:0]  rank_ff  [ENTRIES];
   logic [RANK_BITS-1:0]  rank_in  [ENTRIES];
   logic [OCC_BITS-1:0]   occ_ff, occ_in;

   logic [ENTRIES-1:0]    match, lru, evict, kept, free_vec, slot;
   logic [RANK_BITS-1:0]  hit_rank;
   logic [VALUE_BITS-1:0] hit_value;
   logic                  any_hit, full;
   logic [OCC_BITS-1:0]   cap_eff, occ_last;

   // Clamp the capacity to the range the store supports.
   always_comb begin
      if (capacity == '0) begin
         cap_eff = OCC_BITS'(1);
      end else if (int'(capacity) > ENTRIES) begin
         cap_eff = OCC_BITS'(ENTRIES);
      end else begin
         cap_eff = OCC_BITS'(capacity);
      end
   end

   assign full     = (occ_ff >= cap_eff);
   assign occ_last = occ_ff - 1'b1;

   // Valid keys are unique and valid ranks are distinct, so both the key
   // match and the least recent entry (rank occupancy-1) are one-hot.
   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == cmd.key);
         lru[i]   = valid_ff[i] && (OCC_BITS'(rank_ff[i]) == occ_last);
         hit_rank  = hit_rank  | (match[i] ? rank_ff[i]  : '0);
         hit_value = hit_value | (match[i] ? value_ff[i] : '0);
      end
   end

   assign any_hit = |match;

   // On a miss into a full store the least recent entry makes room; the new
   // entry takes the lowest free slot.
   assign evict    = full ? lru : '0;
   assign kept     = valid_ff & ~evict;
   assign free_vec = ~kept;
   assign slot     = free_vec & (~free_vec + 1'b1);

   // Next state of every entry.
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         rank_in[i]  = rank_ff[i];
      end
      if (cmd_valid) begin
         unique case (cmd.action) inside
            ACT_LOOKUP, ACT_INSERT: begin
               if (any_hit) begin
                  // Move the hit entry to the front; newer entries age by one.
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (match[i]) begin
                        rank_in[i] = '0;
                        if (cmd.action == ACT_INSERT) begin
                           value_in[i] = cmd.value;
                        end
                     end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                        rank_in[i] = rank_ff[i] + 1'b1;
                     end
                  end
               end else if (cmd.action == ACT_INSERT) begin
                  // Fill a new entry as most recent; all survivors age by one.
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (slot[i]) begin
                        key_in[i]   = cmd.key;
                        value_in[i] = cmd.value;
                        rank_in[i]  = '0;
                     end else if (kept[i]) begin
                        rank_in[i] = rank_ff[i] + 1'b1;
                     end
                  end
                  valid_in = kept | slot;
                  occ_in   = full ? occ_ff : occ_ff + 1'b1;
               end
            end
            ACT_CLEAR: begin
               valid_in = '0;
               occ_in   = '0;
               for (int i = 0; i < ENTRIES; i++) begin
                  rank_in[i] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control state: valid marks, ranks and the fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Payload: keys and values are only read once written.
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i]   <= key_in[i];
         value_ff[i] <= value_in[i];
      end
   end

   // Result of the current command.
   always_comb begin
      rsp.hit        = any_hit && ((cmd.action == ACT_LOOKUP) || (cmd.action == ACT_INSERT));
      rsp.read_value = (any_hit && (cmd.action == ACT_LOOKUP)) ? hit_value : '0;
      rsp.occupancy  = OCC_OUT_BITS'(occ_in);
   end

endmodule

### sv/lkvc_checker.sv
// Port-level checks of the LRU key-value cache and their binding.
module lkvc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lkvc_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import lkvc_pkg::*;

   // A stalled response word holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   // No response word comes out of reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response word right after reset");

   // A nonzero read value only comes with a hit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[VALUE_BITS:1] != '0) |-> rsp_tdata[0])
      else $error("read value without a hit");

   // Occupancy never exceeds the number of entries.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(rsp_tdata[VALUE_BITS+1 +: OCC_OUT_BITS]) <= ENTRIES)
      else $error("occupancy beyond the store size");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
